/* rtl/core/modbus_rtu_request_framer_top_macros.svh */
// Assertion macros for the Modbus RTU request framer.
// Used by the frame serialiser; no other dependencies.
`ifndef MODBUS_RTU_REQUEST_FRAMER_TOP_MACROS_SVH
`define MODBUS_RTU_REQUEST_FRAMER_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, disabled while in reset.
`define MRF_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mrf assertion failed");

// Next-cycle implication, disabled while in reset.
`define MRF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mrf assertion failed");

`else

`define MRF_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define MRF_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* rtl/core/mrf_pkg.sv */
// Shared types, constants and the CRC-16/MODBUS byte update for the framer.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrf_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned FrameLen = 8;
  localparam int unsigned IdxW    = $clog2(FrameLen);

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Byte positions within the frame
  localparam logic [IdxW-1:0] ByteAddr   = 3'd0;
  localparam logic [IdxW-1:0] ByteFunc   = 3'd1;
  localparam logic [IdxW-1:0] ByteRegHi  = 3'd2;
  localparam logic [IdxW-1:0] ByteRegLo  = 3'd3;
  localparam logic [IdxW-1:0] ByteOpHi   = 3'd4;
  localparam logic [IdxW-1:0] ByteOpLo   = 3'd5;
  localparam logic [IdxW-1:0] ByteCrcLo  = 3'd6;
  localparam logic [IdxW-1:0] ByteCrcHi  = 3'd7;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] register_address;
    logic [15:0] operand_word;
  } req_t;

  // One byte of reflected CRC-16, bit by bit (eight shift steps).
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < ByteW; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mrf_req_buf.sv */
// One-entry request register in front of the frame serialiser.
// Depends on mrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrf_req_buf (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire mrf_pkg::req_t  req_i,
  output logic                pend_valid_o,
  output mrf_pkg::req_t       pend_req_o,
  input  wire logic           pend_take_i
);

  logic          pend_v_q, pend_v_d;
  mrf_pkg::req_t req_q;
  logic          accept;

  assign in_stall_o = pend_v_q;
  assign accept     = in_valid_i && !pend_v_q;

  always_comb begin
    pend_v_d = pend_v_q;
    if (accept) begin
      pend_v_d = 1'b1;
    end else if (pend_take_i) begin
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
    end else begin
      pend_v_q <= pend_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
  end

  assign pend_valid_o = pend_v_q;
  assign pend_req_o   = req_q;

endmodule

`default_nettype wire

/* rtl/core/mrf_frame_ser.sv */
// Frame serialiser: emits the six body bytes and the running CRC, one byte a cycle while not stalled.
// Depends on mrf_pkg and the framer assertion macros.
`timescale 1ns / 1ps
`default_nettype none

`include "modbus_rtu_request_framer_top_macros.svh"

module mrf_frame_ser (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           pend_valid_i,
  input  wire mrf_pkg::req_t  pend_req_i,
  output logic                pend_take_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [7:0]          frame_byte_o,
  output logic                last_byte_o
);

  logic                      active_q, active_d;
  logic [mrf_pkg::IdxW-1:0]  idx_q, idx_d;
  mrf_pkg::req_t             body_q;
  logic [15:0]               crc_q;
  logic [7:0]                cur_byte;
  logic                      out_acc;
  logic                      is_last;
  logic                      load;

  always_comb begin
    case (idx_q)
      mrf_pkg::ByteAddr:  cur_byte = body_q.slave_address;
      mrf_pkg::ByteFunc:  cur_byte = body_q.function_code;
      mrf_pkg::ByteRegHi: cur_byte = body_q.register_address[15:8];
      mrf_pkg::ByteRegLo: cur_byte = body_q.register_address[7:0];
      mrf_pkg::ByteOpHi:  cur_byte = body_q.operand_word[15:8];
      mrf_pkg::ByteOpLo:  cur_byte = body_q.operand_word[7:0];
      mrf_pkg::ByteCrcLo: cur_byte = crc_q[7:0];
      mrf_pkg::ByteCrcHi: cur_byte = crc_q[15:8];
      default:            cur_byte = body_q.slave_address;
    endcase
  end

  assign is_last     = (idx_q == mrf_pkg::ByteCrcHi);
  assign out_acc     = active_q && !out_stall_i;
  // Next frame loads when idle or as the final byte leaves
  assign load        = !active_q || (out_acc && is_last);
  assign pend_take_o = load && pend_valid_i;

  assign out_valid_o  = active_q;
  assign frame_byte_o = cur_byte;
  assign last_byte_o  = is_last;

  always_comb begin
    active_d = active_q;
    idx_d    = idx_q;
    if (pend_take_o) begin
      active_d = 1'b1;
      idx_d    = mrf_pkg::ByteAddr;
    end else if (out_acc) begin
      idx_d = idx_q + 3'd1;
      if (is_last) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= mrf_pkg::ByteAddr;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
    end
  end

  // CRC folds in each body byte as it is sent; final by the CRC low position
  always_ff @(posedge clk_i) begin
    if (pend_take_o) begin
      body_q <= pend_req_i;
      crc_q  <= mrf_pkg::CrcInit;
    end else if (out_acc && (idx_q < mrf_pkg::ByteCrcLo)) begin
      crc_q <= mrf_pkg::crc_byte(crc_q, cur_byte);
    end
  end

  `MRF_ASSERT_NXT(a_step_idx, clk_i, rst_ni, out_acc && !is_last, active_q && (idx_q == 3'($past(idx_q) + 3'd1)))
  `MRF_ASSERT_NXT(a_load_start, clk_i, rst_ni, pend_take_o, active_q && (idx_q == mrf_pkg::ByteAddr))
  `MRF_ASSERT_NXT(a_drain_idle, clk_i, rst_ni, out_acc && is_last && !pend_valid_i, !active_q)
  `MRF_ASSERT_NOW(a_no_take_busy, clk_i, rst_ni, active_q && !is_last, !pend_take_o)

endmodule

`default_nettype wire

/* rtl/core/modbus_rtu_request_framer_top.sv */
// Modbus RTU request framer, one request in gives an 8-byte frame out
// (address, function, register hi/lo, operand hi/lo, CRC lo/hi). The output
// runs one byte per cycle while out_stall_i is low, set by the byte serialiser. The
// request register can hold one further request while the current frame
// is still going out. When the block is idle, an accepted request is held in
// the request register and then loaded into the serialiser, which puts the
// first byte on the output. last_byte_o marks the CRC high byte.
// Depends on mrf_pkg, mrf_req_buf and mrf_frame_ser.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_request_framer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  slave_address_i,
  input  wire logic [7:0]  function_code_i,
  input  wire logic [15:0] register_address_i,
  input  wire logic [15:0] operand_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       frame_byte_o,
  output logic             last_byte_o
);

  mrf_pkg::req_t req_in;
  mrf_pkg::req_t pend_req;
  logic          pend_valid;
  logic          pend_take;

  assign req_in.slave_address    = slave_address_i;
  assign req_in.function_code    = function_code_i;
  assign req_in.register_address = register_address_i;
  assign req_in.operand_word     = operand_word_i;

  mrf_req_buf u_req_buf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_i        (req_in),
    .pend_valid_o (pend_valid),
    .pend_req_o   (pend_req),
    .pend_take_i  (pend_take)
  );

  mrf_frame_ser u_frame_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pend_valid_i (pend_valid),
    .pend_req_i   (pend_req),
    .pend_take_o  (pend_take),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

`default_nettype wire
